>>> design/vrst_pkg.sv
// Shared types and constants for the vertex rotate/scale/translate pipeline.
`default_nettype none

package vrst_pkg;

    // Fixed field widths of the configuration registers
    localparam int TRIG_WIDTH      = 16;
    localparam int SCALE_WIDTH     = 16;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int CFG_DATA_WIDTH  = 48;
    localparam int CFG_INDEX_WIDTH = 3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ROT_YZ   = 3'd0,
        REG_ROT_XZ   = 3'd1,
        REG_ROT_XY   = 3'd2,
        REG_SCALE    = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_OFFSET_Z = 3'd6
    } cfg_reg_t;

    // One planar rotation: cosine in the upper half, sine in the lower half
    typedef struct packed {
        logic signed [TRIG_WIDTH-1:0] cosv;
        logic signed [TRIG_WIDTH-1:0] sinv;
    } rot_t;

    // Per-axis scale factors, x in the top bits
    typedef struct packed {
        logic signed [SCALE_WIDTH-1:0] kx;
        logic signed [SCALE_WIDTH-1:0] ky;
        logic signed [SCALE_WIDTH-1:0] kz;
    } scale_t;

    localparam rot_t   ROT_RESET   = '{cosv: 16'sh4000, sinv: 16'sh0000};
    localparam scale_t SCALE_RESET = '{kx: 16'sh0100, ky: 16'sh0100, kz: 16'sh0100};

endpackage

`default_nettype wire

>>> design/vertex_rotate_scale_translate.sv
// Top level: configuration registers, stream ports and the transform pipeline.
//
// Usage: each item on the s_axis channel is one vertex (x, y, z, signed fixed point
// with 16 fraction bits at the default width). The block rotates it in the YZ, XZ
// and XY planes with the configured cosine/sine pairs, scales each axis by a signed
// Q8.8 factor, adds a per-axis offset and sends the vertex on m_axis. m_axis_tuser
// is set when any step clamped a coordinate to the representable range.
// Pipeline: nine register stages, two per rotation (products, then sum/shift/clamp)
// and three for scale and offset. It takes one vertex per cycle while m_axis_tready
// is high; every stage register is the limit, none is shared.
// Each stage holds its item while the next one is full, so a stall on m_axis_tready
// backs up stage by stage and empty stages keep taking items; nothing is dropped.
// Reset (aresetn low, synchronous) empties the pipeline and loads identity rotations,
// unit scale and zero offsets. Write registers only while the pipeline is empty.
`default_nettype none

module vertex_rotate_scale_translate #(
    parameter int COORD_WIDTH    = 32,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [vrst_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [vrst_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata,
    // input vertices
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // s_axis_tdata, low bit up: in_x, in_y, in_z, zero fill to whole bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // result vertices
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // m_axis_tdata, low bit up: out_x, out_y, out_z, zero fill to whole bytes
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // m_axis_tuser: overflow
    output logic                                   m_axis_tuser
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = ((3*COORD_WIDTH+7)/8)*8;

    vrst_pkg::rot_t   rot_yz_reg, rot_xz_reg, rot_xy_reg;
    vrst_pkg::scale_t scale_reg;
    logic signed [CW-1:0] offset_x_reg, offset_y_reg, offset_z_reg;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_yz_reg   <= vrst_pkg::ROT_RESET;
            rot_xz_reg   <= vrst_pkg::ROT_RESET;
            rot_xy_reg   <= vrst_pkg::ROT_RESET;
            scale_reg    <= vrst_pkg::SCALE_RESET;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end else if (cfg_we) begin
            case (vrst_pkg::cfg_reg_t'(cfg_index))
                vrst_pkg::REG_ROT_YZ:   rot_yz_reg   <= cfg_wdata[31:0];
                vrst_pkg::REG_ROT_XZ:   rot_xz_reg   <= cfg_wdata[31:0];
                vrst_pkg::REG_ROT_XY:   rot_xy_reg   <= cfg_wdata[31:0];
                vrst_pkg::REG_SCALE:    scale_reg    <= cfg_wdata[47:0];
                vrst_pkg::REG_OFFSET_X: offset_x_reg <= cfg_wdata[CW-1:0];
                vrst_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_wdata[CW-1:0];
                vrst_pkg::REG_OFFSET_Z: offset_z_reg <= cfg_wdata[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    logic signed [CW-1:0] in_x, in_y, in_z;
    assign in_x = s_axis_tdata[CW-1:0];
    assign in_y = s_axis_tdata[2*CW-1:CW];
    assign in_z = s_axis_tdata[3*CW-1:2*CW];

    logic                 v1, r1, o1, v2, r2, o2, v3, r3, o3;
    logic signed [CW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
    logic signed [CW-1:0] sc_in [3];
    logic signed [CW-1:0] sc_out [3];
    logic                 sc_ovf;

    // YZ plane: a = y, b = z
    vrst_rotate #(.CW(CW), .TFB(TRIG_FRAC_BITS)) u_rot_yz (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rot       (rot_yz_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_a      (in_y),
        .in_b      (in_z),
        .in_c      (in_x),
        .in_ovf    (1'b0),
        .out_valid (v1),
        .out_ready (r1),
        .out_a     (y1),
        .out_b     (z1),
        .out_c     (x1),
        .out_ovf   (o1)
    );

    // XZ plane: a = x, b = z
    vrst_rotate #(.CW(CW), .TFB(TRIG_FRAC_BITS)) u_rot_xz (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rot       (rot_xz_reg),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_a      (x1),
        .in_b      (z1),
        .in_c      (y1),
        .in_ovf    (o1),
        .out_valid (v2),
        .out_ready (r2),
        .out_a     (x2),
        .out_b     (z2),
        .out_c     (y2),
        .out_ovf   (o2)
    );

    // XY plane: a = x, b = y
    vrst_rotate #(.CW(CW), .TFB(TRIG_FRAC_BITS)) u_rot_xy (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rot       (rot_xy_reg),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_a      (x2),
        .in_b      (y2),
        .in_c      (z2),
        .in_ovf    (o2),
        .out_valid (v3),
        .out_ready (r3),
        .out_a     (x3),
        .out_b     (y3),
        .out_c     (z3),
        .out_ovf   (o3)
    );

    assign sc_in[0] = x3;
    assign sc_in[1] = y3;
    assign sc_in[2] = z3;

    vrst_scale_offset #(.CW(CW)) u_scale_offset (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scale     (scale_reg),
        .offset_x  (offset_x_reg),
        .offset_y  (offset_y_reg),
        .offset_z  (offset_z_reg),
        .in_valid  (v3),
        .in_ready  (r3),
        .in_v      (sc_in),
        .in_ovf    (o3),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_v     (sc_out),
        .out_ovf   (sc_ovf)
    );

    // Pack the result, zero fill above the coordinates
    assign m_axis_tdata = DW'({sc_out[2], sc_out[1], sc_out[0]});
    assign m_axis_tuser = sc_ovf;

endmodule

`default_nettype wire

>>> design/vrst_rotate.sv
// One planar rotation: product stage, then sum, floor shift and saturate stage.
`default_nettype none

module vrst_rotate #(
    parameter int CW  = 32,
    parameter int TFB = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vrst_pkg::rot_t       rot,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] in_a,
    input  logic signed [CW-1:0] in_b,
    input  logic signed [CW-1:0] in_c,
    input  logic                 in_ovf,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] out_a,
    output logic signed [CW-1:0] out_b,
    output logic signed [CW-1:0] out_c,
    output logic                 out_ovf
);

    localparam int PW = CW + vrst_pkg::TRIG_WIDTH;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic                 mul_valid_reg;
    logic                 mul_ready;
    logic signed [PW-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [PW-1:0] ac_next, bs_next, as_next, bc_next;
    logic signed [CW-1:0] c1_reg;
    logic                 ovf1_reg;

    logic                 sum_valid_reg;
    logic                 sum_ready;
    logic signed [CW-1:0] a_reg, b_reg, c2_reg;
    logic signed [CW-1:0] a_next, b_next;
    logic                 ovf2_reg;
    logic                 ovf_next;

    logic signed [PW:0]   sum_a, sum_b, sh_a, sh_b;
    logic                 over_a, over_b;

    // Stall a stage only when it holds an item that cannot move on
    assign sum_ready = !sum_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || sum_ready;
    assign in_ready  = mul_ready;

    // Form the four exact products
    always_comb begin
        ac_next = in_a * rot.cosv;
        bs_next = in_b * rot.sinv;
        as_next = in_a * rot.sinv;
        bc_next = in_b * rot.cosv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid) begin
            ac_reg   <= ac_next;
            bs_reg   <= bs_next;
            as_reg   <= as_next;
            bc_reg   <= bc_next;
            c1_reg   <= in_c;
            ovf1_reg <= in_ovf;
        end
    end

    // Sum exactly, floor-shift the fraction away, clamp to the coordinate range
    always_comb begin
        sum_a  = {ac_reg[PW-1], ac_reg} - {bs_reg[PW-1], bs_reg};
        sum_b  = {as_reg[PW-1], as_reg} + {bc_reg[PW-1], bc_reg};
        sh_a   = sum_a >>> TFB;
        sh_b   = sum_b >>> TFB;
        over_a = !((&sh_a[PW:CW-1]) || !(|sh_a[PW:CW-1]));
        over_b = !((&sh_b[PW:CW-1]) || !(|sh_b[PW:CW-1]));
        if (over_a) begin
            a_next = sh_a[PW] ? CMIN : CMAX;
        end else begin
            a_next = sh_a[CW-1:0];
        end
        if (over_b) begin
            b_next = sh_b[PW] ? CMIN : CMAX;
        end else begin
            b_next = sh_b[CW-1:0];
        end
        ovf_next = ovf1_reg || over_a || over_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_ready) begin
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_ready && mul_valid_reg) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c2_reg   <= c1_reg;
            ovf2_reg <= ovf_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_c     = c2_reg;
    assign out_ovf   = ovf2_reg;

endmodule

`default_nettype wire

>>> design/vrst_scale_offset.sv
// Per-axis scale (multiply, floor shift, saturate) and offset add with saturation.
`default_nettype none

module vrst_scale_offset #(
    parameter int CW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vrst_pkg::scale_t     scale,
    input  logic signed [CW-1:0] offset_x,
    input  logic signed [CW-1:0] offset_y,
    input  logic signed [CW-1:0] offset_z,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] in_v [3],
    input  logic                 in_ovf,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] out_v [3],
    output logic                 out_ovf
);

    localparam int PW = CW + vrst_pkg::SCALE_WIDTH;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic signed [vrst_pkg::SCALE_WIDTH-1:0] k [3];
    logic signed [CW-1:0]                    off [3];

    logic                 mul_valid_reg, shf_valid_reg, add_valid_reg;
    logic                 mul_ready, shf_ready, add_ready;
    logic signed [PW-1:0] prod_reg [3];
    logic signed [PW-1:0] prod_next [3];
    logic signed [CW-1:0] shf_reg [3];
    logic signed [CW-1:0] shf_next [3];
    logic signed [CW-1:0] add_reg [3];
    logic signed [CW-1:0] add_next [3];
    logic                 ovf1_reg, ovf2_reg, ovf3_reg;
    logic                 ovf2_next, ovf3_next;
    logic signed [PW-1:0] sh [3];
    logic signed [CW:0]   sum [3];
    logic [2:0]           over_s, over_a;

    assign k[0]   = scale.kx;
    assign k[1]   = scale.ky;
    assign k[2]   = scale.kz;
    assign off[0] = offset_x;
    assign off[1] = offset_y;
    assign off[2] = offset_z;

    // Stall a stage only when it holds an item that cannot move on
    assign add_ready = !add_valid_reg || out_ready;
    assign shf_ready = !shf_valid_reg || add_ready;
    assign mul_ready = !mul_valid_reg || shf_ready;
    assign in_ready  = mul_ready;

    // Lane arithmetic: product, floor shift with clamp, offset add with clamp
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_next[i] = in_v[i] * k[i];
            sh[i]        = prod_reg[i] >>> vrst_pkg::SCALE_FRAC_BITS;
            over_s[i]    = !((&sh[i][PW-1:CW-1]) || !(|sh[i][PW-1:CW-1]));
            if (over_s[i]) begin
                shf_next[i] = sh[i][PW-1] ? CMIN : CMAX;
            end else begin
                shf_next[i] = sh[i][CW-1:0];
            end
            sum[i]    = {shf_reg[i][CW-1], shf_reg[i]} + {off[i][CW-1], off[i]};
            over_a[i] = sum[i][CW] != sum[i][CW-1];
            if (over_a[i]) begin
                add_next[i] = sum[i][CW] ? CMIN : CMAX;
            end else begin
                add_next[i] = sum[i][CW-1:0];
            end
        end
        ovf2_next = ovf1_reg || (|over_s);
        ovf3_next = ovf2_reg || (|over_a);
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            shf_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end else begin
            if (mul_ready) begin
                mul_valid_reg <= in_valid;
            end
            if (shf_ready) begin
                shf_valid_reg <= mul_valid_reg;
            end
            if (add_ready) begin
                add_valid_reg <= shf_valid_reg;
            end
        end
    end

    // Load payload only when an item moves into the stage
    always_ff @(posedge aclk) begin
        if (mul_ready && in_valid) begin
            prod_reg <= prod_next;
            ovf1_reg <= in_ovf;
        end
        if (shf_ready && mul_valid_reg) begin
            shf_reg  <= shf_next;
            ovf2_reg <= ovf2_next;
        end
        if (add_ready && shf_valid_reg) begin
            add_reg  <= add_next;
            ovf3_reg <= ovf3_next;
        end
    end

    assign out_valid = add_valid_reg;
    assign out_v     = add_reg;
    assign out_ovf   = ovf3_reg;

endmodule

`default_nettype wire
